@@ sv/irig_pkg.sv @@
`timescale 1ns / 1ps
// Package for the IRIG PWM frame decoder: codes, limits and the records
// passed between the front end, the pulse queue and the frame tracker.
// No dependencies.
package irig_pkg;

    // Frame geometry
    localparam int INFO_SLOTS     = 10;
    localparam int FRAME_BUFFERS  = 2;
    localparam int SLOT_W         = 4;
    localparam int POS_W          = 4;
    localparam int BUF_W          = 1;
    localparam int WORD_W         = 10;
    localparam int TIME_W         = 32;
    localparam int WIDE_W         = 64;

    // Position 100 is slot 10, digit 0
    localparam logic [SLOT_W-1:0] FRAME_END_SLOT = SLOT_W'(10);
    localparam logic [POS_W-1:0]  MARKER_POS     = POS_W'(9);
    localparam logic [POS_W-1:0]  LAST_POS       = POS_W'(9);

    // Limit reset values
    localparam logic [TIME_W-1:0] ZERO_LIMIT_RST   = 32'd700000;
    localparam logic [TIME_W-1:0] ONE_LIMIT_RST    = 32'd1300000;
    localparam logic [TIME_W-1:0] MARKER_LIMIT_RST = 32'd2457600;

    // Pulse queue depth
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_ZERO_LIMIT   = 2'd0,
        CFG_ONE_LIMIT    = 2'd1,
        CFG_MARKER_LIMIT = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        PULSE_ZERO   = 2'd0,
        PULSE_ONE    = 2'd1,
        PULSE_MARKER = 2'd2,
        PULSE_ERROR  = 2'd3
    } pulse_t;

    typedef enum logic [2:0] {
        EV_LOCK    = 3'd0,
        EV_HUNT    = 3'd1,
        EV_INFO    = 3'd2,
        EV_MARKER  = 3'd3,
        EV_DESYNC  = 3'd4,
        EV_FRAME   = 3'd5
    } event_t;

    typedef struct packed {
        logic [TIME_W-1:0] zero_limit;
        logic [TIME_W-1:0] one_limit;
        logic [TIME_W-1:0] marker_limit;
    } limits_t;

    // One measured pulse, pushed on a falling edge
    typedef struct packed {
        logic [WIDE_W-1:0] width;
        logic [TIME_W-1:0] rise_low;
        logic [TIME_W-1:0] overflow;
    } pulse_rec_t;

    typedef struct packed {
        logic       valid;
        pulse_rec_t rec;
    } pulse_push_t;

    typedef struct packed {
        event_t             event_kind;
        pulse_t             pulse_kind;
        logic [BUF_W-1:0]   buffer_index;
        logic [SLOT_W-1:0]  slot_index;
        logic [WORD_W-1:0]  info_word;
        logic [TIME_W-1:0]  edge_time;
        logic [TIME_W-1:0]  edge_overflow;
        logic [1:0]         ready_value;
        logic               desync_flag;
    } result_t;

endpackage

@@ sv/irig_front.sv @@
`timescale 1ns / 1ps
// Front end: edge detection on the sampled line, rising-edge time capture
// and 64-bit pulse width on each falling edge. Uses irig_pkg.
module irig_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      sample_fire,
    input  logic                      level,
    input  logic [31:0]               timer_count,
    input  logic [31:0]               wrap_count,
    output irig_pkg::pulse_push_t     push
);
    import irig_pkg::*;

    logic              prev_level_reg;
    logic              prev_level_next;
    logic [WIDE_W-1:0] rise_full_reg;
    logic [WIDE_W-1:0] rise_full_next;
    logic [TIME_W-1:0] rise_low_reg;
    logic [TIME_W-1:0] rise_low_next;
    logic [WIDE_W-1:0] now_time;
    logic              is_edge;

    assign now_time = {wrap_count, timer_count};
    assign is_edge  = sample_fire && (level != prev_level_reg);

    // Edge tracking and rising-edge capture
    always_comb
    begin
        prev_level_next = prev_level_reg;
        rise_full_next  = rise_full_reg;
        rise_low_next   = rise_low_reg;
        if (is_edge)
        begin
            prev_level_next = level;
            if (level)
            begin
                rise_full_next = now_time;
                rise_low_next  = timer_count;
            end
        end
    end

    // Falling edge: hand the pulse to the queue
    always_comb
    begin
        push.valid        = is_edge && !level;
        push.rec.width    = now_time - rise_full_reg;
        push.rec.rise_low = rise_low_reg;
        push.rec.overflow = wrap_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= 1'b0;
            rise_full_reg  <= '0;
            rise_low_reg   <= '0;
        end
        else
        begin
            prev_level_reg <= prev_level_next;
            rise_full_reg  <= rise_full_next;
            rise_low_reg   <= rise_low_next;
        end
    end

endmodule

@@ sv/irig_queue.sv @@
`timescale 1ns / 1ps
// Two-entry pulse queue between the front end and the frame tracker.
// Uses irig_pkg.
module irig_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  irig_pkg::pulse_push_t push,
    output logic                  full,
    output logic                  pop_valid,
    input  logic                  pop,
    output irig_pkg::pulse_rec_t  pop_rec
);
    import irig_pkg::*;

    pulse_rec_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_rec   = entry_reg[rd_ptr_reg];
    assign do_push   = push.valid && !full;
    assign do_pop    = pop && pop_valid;

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push.rec;
    end

endmodule

@@ sv/irig_back.sv @@
`timescale 1ns / 1ps
// Frame tracker: classifies each queued pulse, runs lock and bit position,
// merges info bits into the double-buffered word store and registers the
// result. Uses irig_pkg.
module irig_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  irig_pkg::limits_t    limits,
    input  logic                 pop_valid,
    input  irig_pkg::pulse_rec_t pop_rec,
    output logic                 pop,
    output logic                 result_valid,
    input  logic                 result_ready,
    output irig_pkg::result_t    result
);
    import irig_pkg::*;

    logic               locked_reg;
    logic               locked_next;
    pulse_t             last_pulse_reg;
    pulse_t             last_pulse_next;
    logic [SLOT_W-1:0]  slot_reg;
    logic [SLOT_W-1:0]  slot_next;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [BUF_W-1:0]   active_reg;
    logic [BUF_W-1:0]   active_next;
    logic               desync_reg;
    logic               desync_next;
    logic [1:0]         ready_mark_reg;
    logic [1:0]         ready_mark_next;
    logic [WORD_W-1:0]  store_reg [FRAME_BUFFERS][INFO_SLOTS];
    logic               store_we;
    logic [WORD_W-1:0]  merged_word;
    logic [WORD_W-1:0]  old_word;
    logic               out_valid_reg;
    result_t            out_reg;
    result_t            res;
    pulse_t             pulse;
    logic               hi_zero;
    logic [TIME_W-1:0]  lo;
    logic [SLOT_W-1:0]  slot_inc;
    logic [POS_W-1:0]   pos_inc;

    assign pop          = pop_valid && (!out_valid_reg || result_ready);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Pulse width classification; a width on a limit or zero is an error
    assign hi_zero = (pop_rec.width[WIDE_W-1:TIME_W] == '0);
    assign lo      = pop_rec.width[TIME_W-1:0];
    always_comb
    begin
        priority if (hi_zero && lo != '0 && lo < limits.zero_limit)
            pulse = PULSE_ZERO;
        else if (hi_zero && lo > limits.zero_limit && lo < limits.one_limit)
            pulse = PULSE_ONE;
        else if (hi_zero && lo > limits.one_limit && lo < limits.marker_limit)
            pulse = PULSE_MARKER;
        else
            pulse = PULSE_ERROR;
    end

    // Position plus one, as slot and digit
    always_comb
    begin
        if (pos_reg == LAST_POS)
        begin
            pos_inc  = '0;
            slot_inc = slot_reg + 1'b1;
        end
        else
        begin
            pos_inc  = pos_reg + 1'b1;
            slot_inc = slot_reg;
        end
    end

    // Info bit merge: clear the bit, then OR in the pulse code
    assign old_word    = store_reg[active_reg][slot_reg];
    assign merged_word = (old_word & ~(WORD_W'(1) << pos_reg))
                       | (WORD_W'(pulse) << pos_reg);

    // Frame tracker
    always_comb
    begin
        locked_next     = locked_reg;
        last_pulse_next = pulse;
        slot_next       = slot_reg;
        pos_next        = pos_reg;
        active_next     = active_reg;
        desync_next     = desync_reg;
        ready_mark_next = ready_mark_reg;
        store_we        = 1'b0;

        res.event_kind    = EV_HUNT;
        res.pulse_kind    = pulse;
        res.buffer_index  = '0;
        res.slot_index    = '0;
        res.info_word     = '0;
        res.edge_time     = pop_rec.rise_low;
        res.edge_overflow = pop_rec.overflow;

        if (locked_reg)
        begin
            if (slot_reg >= FRAME_END_SLOT)
            begin
                // Frame complete: publish buffer, swap, restart at position 1
                ready_mark_next  = {1'b0, active_reg} + 2'd1;
                active_next      = ~active_reg;
                res.buffer_index = ~active_reg;
                slot_next        = '0;
                pos_next         = POS_W'(1);
                res.event_kind   = EV_FRAME;
            end
            else if (pos_reg == MARKER_POS)
            begin
                res.slot_index   = slot_reg;
                res.buffer_index = active_reg;
                if (pulse != PULSE_MARKER)
                begin
                    locked_next     = 1'b0;
                    ready_mark_next = '0;
                    desync_next     = 1'b1;
                    res.event_kind  = EV_DESYNC;
                end
                else
                begin
                    res.event_kind = EV_MARKER;
                end
                slot_next = slot_inc;
                pos_next  = pos_inc;
            end
            else
            begin
                res.slot_index   = slot_reg;
                res.buffer_index = active_reg;
                res.info_word    = merged_word;
                store_we         = pop;
                slot_next        = slot_inc;
                pos_next         = pos_inc;
                res.event_kind   = EV_INFO;
            end
        end
        else if (pulse == PULSE_MARKER && last_pulse_reg == PULSE_MARKER)
        begin
            // Two markers in a row: frame start
            locked_next      = 1'b1;
            slot_next        = '0;
            pos_next         = POS_W'(1);
            res.buffer_index = active_reg;
            res.event_kind   = EV_LOCK;
        end

        res.ready_value = ready_mark_next;
        res.desync_flag = desync_next;
    end

    // Tracker state, advanced on each popped pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            locked_reg     <= 1'b0;
            last_pulse_reg <= PULSE_ERROR;
            slot_reg       <= '0;
            pos_reg        <= '0;
            active_reg     <= '0;
            desync_reg     <= 1'b0;
            ready_mark_reg <= '0;
        end
        else if (pop)
        begin
            locked_reg     <= locked_next;
            last_pulse_reg <= last_pulse_next;
            slot_reg       <= slot_next;
            pos_reg        <= pos_next;
            active_reg     <= active_next;
            desync_reg     <= desync_next;
            ready_mark_reg <= ready_mark_next;
        end
    end

    // Info word store, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < FRAME_BUFFERS; b++)
                for (int s = 0; s < INFO_SLOTS; s++)
                    store_reg[b][s] <= '0;
        end
        else if (store_we)
        begin
            store_reg[active_reg][slot_reg] <= merged_word;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '{event_kind: EV_HUNT, pulse_kind: PULSE_ERROR, default: '0};
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
            out_reg       <= res;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

@@ sv/irig_pwm_frame_decoder_top.sv @@
`timescale 1ns / 1ps
// Top level of the IRIG PWM frame decoder: limit registers, front end,
// pulse queue and frame tracker. Uses irig_pkg, irig_front, irig_queue,
// irig_back.
//
// Usage:
//   Sample channel (sample_valid/sample_ready): one sample per cycle (queue
//   not full) of the line level, the 32-bit timer and the timer wrap count.
//   Edges are found by comparing against the previously accepted sample.
//   Result channel (result_valid/result_ready): one result per falling edge
//   of the line, no result for other samples.
//   Config channel (cfg_valid/cfg_ready): writes the zero, one and marker
//   width limits by index; cfg_ready is always high, index 3 is ignored.
// Timing:
//   Throughput is one sample per cycle while the queue has room. A falling
//   edge's pulse is registered in the two-entry pulse queue, then in the
//   tracker output register. The tracker merges info bits in the same
//   cycle it reads the word store, so back-to-back pulses wait only on a held result.
// Reset clears edge state, lock, position, flags, limits to their defaults
// and the 20-word info store at once; samples are taken right away.
// When the receiver stalls, the output register holds, the queue fills and
// sample_ready drops once two pulses wait behind the held result.
module irig_pwm_frame_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_ready,
    input  logic        level,
    input  logic [31:0] timer_count,
    input  logic [31:0] wrap_count,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [2:0]  event_kind,
    output logic [1:0]  pulse_kind,
    output logic        buffer_index,
    output logic [3:0]  slot_index,
    output logic [9:0]  info_word,
    output logic [31:0] edge_time,
    output logic [31:0] edge_overflow,
    output logic [1:0]  ready_value,
    output logic        desync_flag,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import irig_pkg::*;

    limits_t     limits_reg;
    limits_t     limits_next;
    pulse_push_t push;
    pulse_rec_t  pop_rec;
    result_t     result;
    logic        q_full;
    logic        pop_valid;
    logic        pop;
    logic        sample_fire;

    assign cfg_ready    = 1'b1;
    assign sample_ready = !q_full;
    assign sample_fire  = sample_valid && sample_ready;

    // Limit registers
    always_comb
    begin
        limits_next = limits_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ZERO_LIMIT:   limits_next.zero_limit   = cfg_data;
                CFG_ONE_LIMIT:    limits_next.one_limit    = cfg_data;
                CFG_MARKER_LIMIT: limits_next.marker_limit = cfg_data;
                default:          limits_next = limits_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.zero_limit   <= ZERO_LIMIT_RST;
            limits_reg.one_limit    <= ONE_LIMIT_RST;
            limits_reg.marker_limit <= MARKER_LIMIT_RST;
        end
        else
        begin
            limits_reg <= limits_next;
        end
    end

    irig_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_fire (sample_fire),
        .level       (level),
        .timer_count (timer_count),
        .wrap_count  (wrap_count),
        .push        (push)
    );

    irig_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (q_full),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_rec   (pop_rec)
    );

    irig_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .limits       (limits_reg),
        .pop_valid    (pop_valid),
        .pop_rec      (pop_rec),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Result fields
    assign event_kind    = result.event_kind;
    assign pulse_kind    = result.pulse_kind;
    assign buffer_index  = result.buffer_index;
    assign slot_index    = result.slot_index;
    assign info_word     = result.info_word;
    assign edge_time     = result.edge_time;
    assign edge_overflow = result.edge_overflow;
    assign ready_value   = result.ready_value;
    assign desync_flag   = result.desync_flag;

endmodule

@@ sv/irig_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the IRIG PWM frame decoder, bound to the top level.
// Uses irig_pkg for the event and pulse codes.
module irig_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_ready,
    input logic [2:0]  event_kind,
    input logic [1:0]  pulse_kind,
    input logic        buffer_index,
    input logic [3:0]  slot_index,
    input logic [9:0]  info_word,
    input logic [1:0]  ready_value,
    input logic        desync_flag
);
    import irig_pkg::*;

    // Stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(event_kind)
            && $stable(info_word) && $stable(slot_index))
        else $error("result changed while stalled");

    // Desync flag is sticky
    a_desync_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(desync_flag))
        else $error("desync flag cleared");

    // Desync drops the ready mark and sets the flag
    a_desync_event: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && event_kind == EV_DESYNC |-> desync_flag && ready_value == 2'd0)
        else $error("desync event without flag or with ready mark");

    // Lock needs a marker pulse
    a_lock_marker: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && event_kind == EV_LOCK |-> pulse_kind == PULSE_MARKER)
        else $error("lock gained on non-marker pulse");

    // Hunting carries no slot, word or buffer
    a_hunt_empty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && event_kind == EV_HUNT
            |-> slot_index == 4'd0 && info_word == 10'd0 && buffer_index == 1'b0)
        else $error("hunting result carries frame data");

endmodule

bind irig_pwm_frame_decoder_top irig_checker u_irig_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .event_kind   (event_kind),
    .pulse_kind   (pulse_kind),
    .buffer_index (buffer_index),
    .slot_index   (slot_index),
    .info_word    (info_word),
    .ready_value  (ready_value),
    .desync_flag  (desync_flag)
);

@@ tb/sv/irig_pwm_frame_decoder_checker.sv @@
`timescale 1ns / 1ps
// Checker for the IRIG PWM frame decoder: watches the sample, config and
// result channels, tracks the decoder state and compares every result.
// Depends on irig_pkg.
module irig_pwm_frame_decoder_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    input  logic        sample_ready,
    input  logic        level,
    input  logic [31:0] timer_count,
    input  logic [31:0] wrap_count,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic [2:0]  event_kind,
    input  logic [1:0]  pulse_kind,
    input  logic        buffer_index,
    input  logic [3:0]  slot_index,
    input  logic [9:0]  info_word,
    input  logic [31:0] edge_time,
    input  logic [31:0] edge_overflow,
    input  logic [1:0]  ready_value,
    input  logic        desync_flag,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    import irig_pkg::*;

    // Width limits as last written
    logic [31:0] lim_zero;
    logic [31:0] lim_one;
    logic [31:0] lim_marker;

    // Edge and frame tracking state
    logic        prev_lvl;
    logic [63:0] rise_full;
    logic [31:0] rise_low;
    logic [6:0]  pos;
    logic        in_lock;
    pulse_t      last_kind;
    logic        cur_buf;
    logic [9:0]  words [0:INFO_SLOTS*FRAME_BUFFERS-1];
    logic        desync_seen;
    logic [1:0]  ready_mark;

    // Results still owed by the decoder, oldest first
    result_t     due_events [$];

    // Pulse width to symbol; a width on a limit or zero is an error
    function automatic pulse_t width_class(input logic [63:0] w);
        if (w != 64'd0 && w < {32'd0, lim_zero})
            return PULSE_ZERO;
        if (w > {32'd0, lim_zero} && w < {32'd0, lim_one})
            return PULSE_ONE;
        if (w > {32'd0, lim_one} && w < {32'd0, lim_marker})
            return PULSE_MARKER;
        return PULSE_ERROR;
    endfunction

    // One accepted sample: update state, queue a result on a falling edge
    task automatic decode_sample(input logic lvl, input logic [31:0] tc,
                                 input logic [31:0] ovf);
        logic [63:0] now_v;
        pulse_t      kind;
        result_t     r;
        logic [4:0]  idx;
        logic [3:0]  digit;
        logic [9:0]  w;
        now_v = {ovf, tc};
        if (lvl == prev_lvl)
            return;
        prev_lvl = lvl;
        if (lvl)
        begin
            rise_full = now_v;
            rise_low  = tc;
            return;
        end
        kind = width_class(now_v - rise_full);
        r = '0;
        r.pulse_kind    = kind;
        r.edge_time     = rise_low;
        r.edge_overflow = ovf;
        if (in_lock)
        begin
            if (pos >= 7'd100)
            begin
                // frame end: pulse not checked, buffers swap
                ready_mark     = {1'b0, cur_buf} + 2'd1;
                cur_buf        = ~cur_buf;
                r.buffer_index = cur_buf;
                pos            = 7'd1;
                r.event_kind   = EV_FRAME;
            end
            else if (pos % 10 == 9)
            begin
                r.slot_index   = 4'(pos / 10);
                r.buffer_index = cur_buf;
                if (kind != PULSE_MARKER)
                begin
                    in_lock      = 1'b0;
                    ready_mark   = 2'd0;
                    desync_seen  = 1'b1;
                    r.event_kind = EV_DESYNC;
                end
                else
                    r.event_kind = EV_MARKER;
                pos = pos + 7'd1;
            end
            else
            begin
                // info bit: clear the position, OR in the symbol code
                digit          = 4'(pos % 10);
                r.slot_index   = 4'(pos / 10);
                r.buffer_index = cur_buf;
                idx            = (cur_buf ? 5'd10 : 5'd0) + 5'(pos / 10);
                w              = words[idx];
                w[digit]       = 1'b0;
                w              = w | ({8'd0, kind} << digit);
                words[idx]     = w;
                r.info_word    = w;
                pos            = pos + 7'd1;
                r.event_kind   = EV_INFO;
            end
        end
        else if (kind == PULSE_MARKER && last_kind == PULSE_MARKER)
        begin
            pos            = 7'd1;
            in_lock        = 1'b1;
            r.buffer_index = cur_buf;
            r.event_kind   = EV_LOCK;
        end
        else
            r.event_kind = EV_HUNT;
        last_kind     = kind;
        r.ready_value = ready_mark;
        r.desync_flag = desync_seen;
        due_events.push_back(r);
    endtask

    always @(posedge clk)
    begin
        result_t want;
        result_t seen;
        if (!rst_n)
        begin
            lim_zero    = ZERO_LIMIT_RST;
            lim_one     = ONE_LIMIT_RST;
            lim_marker  = MARKER_LIMIT_RST;
            prev_lvl    = 1'b0;
            rise_full   = '0;
            rise_low    = '0;
            pos         = '0;
            in_lock     = 1'b0;
            last_kind   = PULSE_ERROR;
            cur_buf     = 1'b0;
            desync_seen = 1'b0;
            ready_mark  = 2'd0;
            for (int i = 0; i < INFO_SLOTS * FRAME_BUFFERS; i++)
                words[i] = '0;
            due_events.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // limit writes; index 3 is dropped
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ZERO_LIMIT:   lim_zero   = cfg_data;
                    CFG_ONE_LIMIT:    lim_one    = cfg_data;
                    CFG_MARKER_LIMIT: lim_marker = cfg_data;
                    default: ;
                endcase
            end
            if (sample_valid && sample_ready)
                decode_sample(level, timer_count, wrap_count);
            // compare each accepted result against the oldest owed one
            if (result_valid && result_ready)
            begin
                if (due_events.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result with none owed: ev=%0d pk=%0d",
                                 $realtime, event_kind, pulse_kind);
                end
                else
                begin
                    want = due_events.pop_front();
                    seen.event_kind    = event_t'(event_kind);
                    seen.pulse_kind    = pulse_t'(pulse_kind);
                    seen.buffer_index  = buffer_index;
                    seen.slot_index    = slot_index;
                    seen.info_word     = info_word;
                    seen.edge_time     = edge_time;
                    seen.edge_overflow = edge_overflow;
                    seen.ready_value   = ready_value;
                    seen.desync_flag   = desync_flag;
                    if (seen !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: mismatch expected ev=%0d pk=%0d buf=%0d slot=%0d",
                                     $realtime, want.event_kind, want.pulse_kind,
                                     want.buffer_index, want.slot_index);
                            $display("    word=%h t=%h ovf=%h rdy=%0d ds=%0d",
                                     want.info_word, want.edge_time, want.edge_overflow,
                                     want.ready_value, want.desync_flag);
                            $display("  actual ev=%0d pk=%0d buf=%0d slot=%0d",
                                     seen.event_kind, seen.pulse_kind,
                                     seen.buffer_index, seen.slot_index);
                            $display("    word=%h t=%h ovf=%h rdy=%0d ds=%0d",
                                     seen.info_word, seen.edge_time, seen.edge_overflow,
                                     seen.ready_value, seen.desync_flag);
                        end
                    end
                end
            end
            pending = due_events.size();
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Top of the IRIG PWM frame decoder testbench: clock, reset, sample and
// limit stimulus, result back-pressure and the verdict.
// Depends on irig_pkg, irig_pwm_frame_decoder_top and the checker module.
module testbench;
    import irig_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        sample_valid;
    logic        sample_ready;
    logic        level;
    logic [31:0] timer_count;
    logic [31:0] wrap_count;
    logic        result_valid;
    logic        result_ready;
    logic [2:0]  event_kind;
    logic [1:0]  pulse_kind;
    logic        buffer_index;
    logic [3:0]  slot_index;
    logic [9:0]  info_word;
    logic [31:0] edge_time;
    logic [31:0] edge_overflow;
    logic [1:0]  ready_value;
    logic        desync_flag;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    int          fail_count;
    int          events_due;

    // Stimulus state: line time, limits in force, frame position as sent
    logic [63:0] line_time;
    logic [31:0] zl;
    logic [31:0] ol;
    logic [31:0] ml;
    int          edge_items;
    bit          send_burst;
    bit          recv_burst;
    int          tx_pos;
    bit          tx_locked;
    pulse_t      tx_last;

    irig_pwm_frame_decoder_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .level          (level),
        .timer_count    (timer_count),
        .wrap_count     (wrap_count),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .event_kind     (event_kind),
        .pulse_kind     (pulse_kind),
        .buffer_index   (buffer_index),
        .slot_index     (slot_index),
        .info_word      (info_word),
        .edge_time      (edge_time),
        .edge_overflow  (edge_overflow),
        .ready_value    (ready_value),
        .desync_flag    (desync_flag),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    irig_pwm_frame_decoder_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .level          (level),
        .timer_count    (timer_count),
        .wrap_count     (wrap_count),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .event_kind     (event_kind),
        .pulse_kind     (pulse_kind),
        .buffer_index   (buffer_index),
        .slot_index     (slot_index),
        .info_word      (info_word),
        .edge_time      (edge_time),
        .edge_overflow  (edge_overflow),
        .ready_value    (ready_value),
        .desync_flag    (desync_flag),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (events_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop well past the slowest legal run
    initial
    begin
        #5_000_000;
        $display("FAIL irig_pwm_frame_decoder_top");
        $finish;
    end

    // Result side: random stall before each request, with bursts of none
    initial
    begin
        int stall;
        result_ready = 1'b0;
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                recv_burst = ~recv_burst;
            stall = recv_burst ? 0 : $urandom_range(0, 15);
            if (stall != 0)
            begin
                result_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ready = 1'b1;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // One sample request at the current line time
    task automatic drive_sample(input logic lvl);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_burst = ~send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            sample_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_valid = 1'b1;
        level        = lvl;
        timer_count  = line_time[31:0];
        wrap_count   = line_time[63:32];
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        edge_items++;
        @(negedge clk);
    endtask

    // Rise, hold for the width, fall; follow the frame position as sent
    task automatic send_pulse(input logic [63:0] width, input pulse_t kind);
        case ($urandom_range(0, 15))
            0: line_time = {$urandom, $urandom};
            1: line_time[31:0] = 32'hFFFF_FFFF - 32'($urandom_range(0, 4095));
            default: line_time = line_time + 64'($urandom_range(1, 1 << 20));
        endcase
        if ($urandom_range(0, 5) == 0)
            drive_sample(1'b0);
        drive_sample(1'b1);
        if ($urandom_range(0, 5) == 0)
            drive_sample(1'b1);
        line_time = line_time + width;
        drive_sample(1'b0);
        if (tx_locked)
        begin
            if (tx_pos >= 100)
                tx_pos = 1;
            else
            begin
                if (tx_pos % 10 == 9 && kind != PULSE_MARKER)
                    tx_locked = 1'b0;
                tx_pos++;
            end
        end
        else if (kind == PULSE_MARKER && tx_last == PULSE_MARKER)
        begin
            tx_locked = 1'b1;
            tx_pos    = 1;
        end
        tx_last = kind;
    endtask

    // Symbol to send next: well-formed frames mostly, rare desync
    function automatic pulse_t choose_kind(input bit noisy);
        if (noisy)
            return pulse_t'($urandom_range(0, 3));
        if (!tx_locked)
            return PULSE_MARKER;
        if (tx_pos >= 100)
            return ($urandom_range(0, 3) == 0) ? pulse_t'($urandom_range(0, 3))
                                               : PULSE_MARKER;
        if (tx_pos % 10 == 9)
            return ($urandom_range(0, 59) == 0) ? pulse_t'($urandom_range(0, 1))
                                                : PULSE_MARKER;
        if ($urandom_range(0, 24) == 0)
            return pulse_t'($urandom_range(2, 3));
        return pulse_t'($urandom_range(0, 1));
    endfunction

    // Width for a symbol under the current limits; an empty band gives error
    task automatic pick_width(input pulse_t want, output logic [63:0] width,
                              output pulse_t got);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] span;
        lo = '0;
        hi = '0;
        case (want)
            PULSE_ZERO:   begin lo = 64'd0;   hi = 64'(zl); end
            PULSE_ONE:    begin lo = 64'(zl); hi = 64'(ol); end
            PULSE_MARKER: begin lo = 64'(ol); hi = 64'(ml); end
            default: ;
        endcase
        if (want != PULSE_ERROR && hi - lo >= 64'd2)
        begin
            span = hi - lo - 64'd1;
            case ($urandom_range(0, 7))
                0: width = lo + 64'd1;
                1: width = hi - 64'd1;
                default: width = lo + 64'd1 + ({$urandom, $urandom} % span);
            endcase
            got = want;
        end
        else
        begin
            got = PULSE_ERROR;
            case ($urandom_range(0, 5))
                0: width = 64'd0;
                1: width = 64'(zl);
                2: width = 64'(ol);
                3: width = 64'(ml);
                4: width = 64'(ml) + 64'd1 + 64'($urandom_range(0, 1 << 20));
                default: width = 64'd0 - 64'($urandom_range(1, 1 << 20));
            endcase
        end
    endtask

    // Wait for the decoder to drain before touching the limits
    task automatic settle();
        sample_valid = 1'b0;
        while (events_due != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_cfg(input cfg_index_t idx, input logic [31:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_limits(input logic [31:0] z, input logic [31:0] o,
                              input logic [31:0] m, input bit poke_unused);
        settle();
        write_cfg(CFG_ZERO_LIMIT, z);
        write_cfg(CFG_ONE_LIMIT, o);
        write_cfg(CFG_MARKER_LIMIT, m);
        if (poke_unused)
            write_cfg(CFG_UNUSED, $urandom);
        cfg_valid = 1'b0;
        zl = z;
        ol = o;
        ml = m;
    endtask

    // Random pulses in segments, mostly well-formed, some noise
    task automatic run_phase(input int budget);
        int          start;
        int          seg;
        bit          noisy;
        pulse_t      kind;
        pulse_t      got;
        logic [63:0] w;
        start = edge_items;
        seg   = 0;
        noisy = 1'b0;
        while (edge_items - start < budget)
        begin
            if (seg == 0)
            begin
                noisy = ($urandom_range(0, 7) == 0);
                seg   = $urandom_range(10, 40);
            end
            kind = choose_kind(noisy);
            pick_width(kind, w, got);
            send_pulse(w, got);
            seg--;
        end
    endtask

    initial
    begin
        int          waited;
        logic [31:0] z;
        logic [31:0] o;
        rst_n          = 1'b0;
        sample_valid   = 1'b0;
        level          = 1'b0;
        timer_count    = '0;
        wrap_count     = '0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_ZERO_LIMIT;
        cfg_data       = '0;
        line_time      = 64'h0000_0001_0000_0000;
        zl             = ZERO_LIMIT_RST;
        ol             = ONE_LIMIT_RST;
        ml             = MARKER_LIMIT_RST;
        edge_items     = 0;
        tx_pos         = 0;
        tx_locked      = 1'b0;
        tx_last        = PULSE_ERROR;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed: widths on and beside each limit, lock, odd info symbols
        send_pulse(64'd0, PULSE_ERROR);
        send_pulse(64'(zl), PULSE_ERROR);
        send_pulse(64'd1, PULSE_ZERO);
        send_pulse(64'(zl) - 64'd1, PULSE_ZERO);
        send_pulse(64'(zl) + 64'd1, PULSE_ONE);
        send_pulse(64'(ol) - 64'd1, PULSE_ONE);
        send_pulse(64'(ol), PULSE_ERROR);
        send_pulse(64'(ml), PULSE_ERROR);
        send_pulse(64'(ml) - 64'd1, PULSE_MARKER);
        send_pulse(64'(ol) + 64'd1, PULSE_MARKER);
        send_pulse(64'(ml) + 64'd5, PULSE_ERROR);
        send_pulse(64'(ol) + 64'd7, PULSE_MARKER);

        // Random phases across limit settings, extremes included
        run_phase(380);
        z = $urandom_range(2, 1000);
        o = z + $urandom_range(2, 1000);
        set_limits(z, o, o + $urandom_range(2, 1000), 1'b0);
        run_phase(300);
        set_limits(32'd0, 32'd0, 32'd0, 1'b0);
        run_phase(40);
        set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        run_phase(40);
        set_limits(32'h7FFF_FFFF, 32'hBFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        run_phase(200);
        set_limits(ZERO_LIMIT_RST, ONE_LIMIT_RST, MARKER_LIMIT_RST, 1'b1);
        run_phase(420);

        // Drain and decide
        sample_valid = 1'b0;
        waited = 0;
        while (events_due != 0 && waited < 5000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (10) @(negedge clk);
        if (fail_count == 0 && events_due == 0)
            $display("PASS irig_pwm_frame_decoder_top");
        else
            $display("FAIL irig_pwm_frame_decoder_top");
        $finish;
    end

endmodule

@@ sim.f @@
sv/irig_pkg.sv
sv/irig_front.sv
sv/irig_queue.sv
sv/irig_back.sv
sv/irig_pwm_frame_decoder_top.sv
sv/irig_checker.sv
tb/sv/irig_pwm_frame_decoder_checker.sv
tb/sv/testbench.sv
